/* design/drop_on_full_ring_with_burst_drain_core_macros.svh */
// Assertion macros for the drop-on-full ring core.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef DROP_ON_FULL_RING_WITH_BURST_DRAIN_CORE_MACROS_SVH
`define DROP_ON_FULL_RING_WITH_BURST_DRAIN_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DOFR_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DOFR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/dofr_pkg.sv */
// Shared types and codes for the drop-on-full ring core.
// No dependencies.
`timescale 1ns / 1ps

package dofr_pkg;

  // Width of the record word on the ports.
  localparam int RECORD_PORT_W = 64;

  typedef logic [RECORD_PORT_W-1:0] record_word_t;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_APPEND = 2'd0;
  localparam mode_t MODE_DRAIN  = 2'd1;
  localparam mode_t MODE_FLUSH  = 2'd2;

  typedef logic [2:0] kind_t;
  localparam kind_t KIND_APPENDED = 3'd0;
  localparam kind_t KIND_DROPPED  = 3'd1;
  localparam kind_t KIND_DRAINED  = 3'd2;
  localparam kind_t KIND_EMPTY    = 3'd3;
  localparam kind_t KIND_FLUSHED  = 3'd4;

endpackage

/* design/dofr_slot_ram.sv */
// Slot storage for the ring: one write port, one read port, registered read data.
// Standalone; sized by the top level's parameters.
`timescale 1ns / 1ps

module dofr_slot_ram #(
  parameter int Depth = 64,
  parameter int Width = 64,
  parameter int AddrW = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/drop_on_full_ring_with_burst_drain_core.sv */
// Drop-on-full ring core; depends on dofr_pkg, dofr_slot_ram and the assertion macros.
// Latency: append, flush and empty-drain results strobe in the cycle after acceptance.
// A drain holds busy_o while its records are read; each record strobes with the registered
// read data of its slot, one per cycle, paced by the single registered read port of the slot RAM.
// Throughput: one transaction per cycle while busy_o is low; results never stall.
// Reset clears pointers, counters and the sequencer; slot contents stay undefined.
`timescale 1ns / 1ps
`include "drop_on_full_ring_with_burst_drain_core_macros.svh"

module drop_on_full_ring_with_burst_drain_core #(
  parameter int RING_SLOTS  = 64,
  parameter int RECORD_BITS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  dofr_pkg::mode_t       mode_i,
  input  dofr_pkg::record_word_t record_in_i,
  input  logic [5:0]            drain_limit_i,
  output logic                  strobe_o,
  output dofr_pkg::kind_t       kind_o,
  output dofr_pkg::record_word_t record_out_o,
  output logic                  last_o,
  output logic [31:0]           dropped_total_o,
  output logic [31:0]           produced_total_o
);

  localparam int IdxW = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam logic [IdxW-1:0] LastSlot = IdxW'(RING_SLOTS - 1);

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_e;

  state_e           state_q, state_d;
  logic [IdxW-1:0]  head_q, head_d;
  logic [IdxW-1:0]  tail_q, tail_d;
  logic [31:0]      drop_q, drop_d;
  logic [31:0]      prod_q, prod_d;
  logic [5:0]       remain_q, remain_d;
  logic             strobe_q, strobe_d;
  dofr_pkg::kind_t  kind_q, kind_d;
  logic             last_q, last_d;
  logic             sel_q, sel_d;

  logic                   ram_we;
  logic                   ram_re;
  logic [RECORD_BITS-1:0] ram_rdata;
  logic [IdxW-1:0]        head_nxt;
  logic [IdxW-1:0]        tail_nxt;

  function automatic logic [IdxW-1:0] adv(input logic [IdxW-1:0] idx);
    adv = (idx == LastSlot) ? '0 : idx + 1'b1;
  endfunction

  assign head_nxt = adv(head_q);
  assign tail_nxt = adv(tail_q);

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    tail_d   = tail_q;
    drop_d   = drop_q;
    prod_d   = prod_q;
    remain_d = remain_q;
    strobe_d = 1'b0;
    kind_d   = kind_q;
    last_d   = 1'b0;
    sel_d    = 1'b0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          unique case (mode_i)
            dofr_pkg::MODE_APPEND: begin
              strobe_d = 1'b1;
              last_d   = 1'b1;
              if (tail_nxt == head_q) begin
                // drop the newest record when full
                drop_d = drop_q + 32'd1;
                kind_d = dofr_pkg::KIND_DROPPED;
              end else begin
                ram_we = 1'b1;
                tail_d = tail_nxt;
                prod_d = prod_q + 32'd1;
                kind_d = dofr_pkg::KIND_APPENDED;
              end
            end
            dofr_pkg::MODE_DRAIN: begin
              if (drain_limit_i == 6'd0 || head_q == tail_q) begin
                strobe_d = 1'b1;
                last_d   = 1'b1;
                kind_d   = dofr_pkg::KIND_EMPTY;
              end else begin
                remain_d = drain_limit_i;
                state_d  = ST_DRAIN;
              end
            end
            dofr_pkg::MODE_FLUSH: begin
              head_d   = tail_q;
              strobe_d = 1'b1;
              last_d   = 1'b1;
              kind_d   = dofr_pkg::KIND_FLUSHED;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DRAIN: begin
        // read the oldest slot; its data shows with next cycle's strobe
        ram_re   = 1'b1;
        head_d   = head_nxt;
        remain_d = remain_q - 6'd1;
        strobe_d = 1'b1;
        sel_d    = 1'b1;
        kind_d   = dofr_pkg::KIND_DRAINED;
        last_d   = (remain_q == 6'd1) || (head_nxt == tail_q);
        if (last_d) begin
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      head_q   <= '0;
      tail_q   <= '0;
      drop_q   <= '0;
      prod_q   <= '0;
      remain_q <= '0;
      strobe_q <= 1'b0;
      kind_q   <= dofr_pkg::KIND_APPENDED;
      last_q   <= 1'b0;
      sel_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      drop_q   <= drop_d;
      prod_q   <= prod_d;
      remain_q <= remain_d;
      strobe_q <= strobe_d;
      kind_q   <= kind_d;
      last_q   <= last_d;
      sel_q    <= sel_d;
    end
  end

  dofr_slot_ram #(
    .Depth (RING_SLOTS),
    .Width (RECORD_BITS),
    .AddrW (IdxW)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (record_in_i[RECORD_BITS-1:0]),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  assign busy_o           = (state_q == ST_DRAIN);
  assign strobe_o         = strobe_q;
  assign kind_o           = kind_q;
  assign last_o           = last_q;
  assign record_out_o     = sel_q ? dofr_pkg::record_word_t'(ram_rdata) : '0;
  assign dropped_total_o  = drop_q;
  assign produced_total_o = prod_q;

  `DOFR_ASSERT_SAME(a_single_last, clk_i, rst_ni,
    strobe_o && (kind_o != dofr_pkg::KIND_DRAINED), last_o,
    "single-result transaction without last")
  `DOFR_ASSERT_SAME(a_zero_record, clk_i, rst_ni,
    strobe_o && (kind_o != dofr_pkg::KIND_DRAINED), record_out_o == '0,
    "record word nonzero outside a drained result")
  `DOFR_ASSERT_SAME(a_drain_nonempty, clk_i, rst_ni,
    state_q == ST_DRAIN, (head_q != tail_q) && (remain_q != 6'd0),
    "drain sequencer running on an empty ring or spent limit")
  `DOFR_ASSERT_NEXT(a_drain_emits, clk_i, rst_ni,
    state_q == ST_DRAIN, strobe_o && (kind_o == dofr_pkg::KIND_DRAINED),
    "drain cycle did not produce a drained result")

endmodule
